@@ hdl/sha256_pkg.sv @@
// Package: SHA-256 constants, round functions and front/back command type.
`timescale 1ns / 1ps
package sha256_pkg;

    localparam int unsigned BLOCK_WORDS = 16;
    localparam int unsigned ROUNDS      = 64;

    // command from byte front end to compression back end
    typedef struct packed {
        logic [511:0] block;
        logic         last_block;
    } blk_cmd_t;

    typedef logic [31:0] word_t;

    localparam word_t H_INIT [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    function automatic word_t round_k(input logic [5:0] r);
        word_t k;
        case (r)
            6'd0: k = 32'h428A2F98;  6'd1: k = 32'h71374491;
            6'd2: k = 32'hB5C0FBCF;  6'd3: k = 32'hE9B5DBA5;
            6'd4: k = 32'h3956C25B;  6'd5: k = 32'h59F111F1;
            6'd6: k = 32'h923F82A4;  6'd7: k = 32'hAB1C5ED5;
            6'd8: k = 32'hD807AA98;  6'd9: k = 32'h12835B01;
            6'd10: k = 32'h243185BE; 6'd11: k = 32'h550C7DC3;
            6'd12: k = 32'h72BE5D74; 6'd13: k = 32'h80DEB1FE;
            6'd14: k = 32'h9BDC06A7; 6'd15: k = 32'hC19BF174;
            6'd16: k = 32'hE49B69C1; 6'd17: k = 32'hEFBE4786;
            6'd18: k = 32'h0FC19DC6; 6'd19: k = 32'h240CA1CC;
            6'd20: k = 32'h2DE92C6F; 6'd21: k = 32'h4A7484AA;
            6'd22: k = 32'h5CB0A9DC; 6'd23: k = 32'h76F988DA;
            6'd24: k = 32'h983E5152; 6'd25: k = 32'hA831C66D;
            6'd26: k = 32'hB00327C8; 6'd27: k = 32'hBF597FC7;
            6'd28: k = 32'hC6E00BF3; 6'd29: k = 32'hD5A79147;
            6'd30: k = 32'h06CA6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27B70A85; 6'd33: k = 32'h2E1B2138;
            6'd34: k = 32'h4D2C6DFC; 6'd35: k = 32'h53380D13;
            6'd36: k = 32'h650A7354; 6'd37: k = 32'h766A0ABB;
            6'd38: k = 32'h81C2C92E; 6'd39: k = 32'h92722C85;
            6'd40: k = 32'hA2BFE8A1; 6'd41: k = 32'hA81A664B;
            6'd42: k = 32'hC24B8B70; 6'd43: k = 32'hC76C51A3;
            6'd44: k = 32'hD192E819; 6'd45: k = 32'hD6990624;
            6'd46: k = 32'hF40E3585; 6'd47: k = 32'h106AA070;
            6'd48: k = 32'h19A4C116; 6'd49: k = 32'h1E376C08;
            6'd50: k = 32'h2748774C; 6'd51: k = 32'h34B0BCB5;
            6'd52: k = 32'h391C0CB3; 6'd53: k = 32'h4ED8AA4A;
            6'd54: k = 32'h5B9CCA4F; 6'd55: k = 32'h682E6FF3;
            6'd56: k = 32'h748F82EE; 6'd57: k = 32'h78A5636F;
            6'd58: k = 32'h84C87814; 6'd59: k = 32'h8CC70208;
            6'd60: k = 32'h90BEFFFA; 6'd61: k = 32'hA4506CEB;
            6'd62: k = 32'hBEF9A3F7; 6'd63: k = 32'hC67178F2;
            default: k = '0;
        endcase
        return k;
    endfunction

    function automatic word_t rotr(input word_t x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

@@ hdl/sha256_front.sv @@
// Front end: packs bytes into blocks, counts length and inserts padding.
`timescale 1ns / 1ps
module sha256_front
    import sha256_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] in_byte,
    input  logic       in_present,
    input  logic       in_last,
    input  logic       in_valid,
    output logic       in_ready,
    output blk_cmd_t   cmd,
    output logic       cmd_valid,
    input  logic       cmd_ready
);

    typedef enum logic [1:0] {ST_BYTES, ST_PAD, ST_LEN, ST_PUSH} fstate_t;

    fstate_t        state_reg;
    logic [511:0]   buf_reg;
    logic [5:0]     pos_reg;
    logic [63:0]    len_reg;
    logic [2:0]     len_idx_reg;
    logic           fin_reg;      // length bytes written: block is the last one
    logic           pad_after_reg; // continue padding after this push
    logic           mark_reg;     // 0x80 still owed to the next block
    blk_cmd_t       cmd_reg;
    logic           cmd_valid_reg;

    logic [7:0]     pad_byte;
    logic [511:0]   buf_next;
    logic [5:0]     pos_next;
    logic           full_last;

    assign in_ready  = (state_reg == ST_BYTES) && !cmd_valid_reg;
    assign cmd       = cmd_reg;
    assign cmd_valid = cmd_valid_reg;

    // final byte lands in the last slot: the 0x80 goes into the next block
    assign full_last = in_present && in_last && (pos_reg == 6'd63);

    always_comb begin
        pad_byte = 8'h00;
        case (state_reg)
            ST_PAD:  pad_byte = mark_reg ? 8'h80 : 8'h00;
            ST_LEN:  pad_byte = len_reg[8*(7-len_idx_reg) +: 8];
            default: pad_byte = 8'h00;
        endcase
    end

    // byte goes into the block at its big-endian place
    function automatic logic [511:0] put(input logic [511:0] b, input logic [5:0] p,
                                         input logic [7:0] v);
        logic [511:0] r;
        r = b;
        r[8*(63-p) +: 8] = v;
        return r;
    endfunction

    always_comb begin
        buf_next = buf_reg;
        pos_next = pos_reg;
        if (in_present) begin
            buf_next = put(buf_next, pos_next, in_byte);
            pos_next = pos_next + 6'd1;
        end
        if (in_last && !full_last) begin
            buf_next = put(buf_next, pos_next, 8'h80);
            pos_next = pos_next + 6'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_BYTES;
            pos_reg       <= '0;
            len_reg       <= '0;
            len_idx_reg   <= '0;
            fin_reg       <= 1'b0;
            pad_after_reg <= 1'b0;
            mark_reg      <= 1'b0;
            cmd_valid_reg <= 1'b0;
        end else begin
            if (cmd_valid_reg && cmd_ready)
                cmd_valid_reg <= 1'b0;
            case (state_reg)
                ST_BYTES: begin
                    if (in_valid && in_ready) begin
                        if (in_present)
                            len_reg <= len_reg + 64'd8;
                        if (in_last)
                            pad_after_reg <= 1'b1;
                        if (full_last)
                            mark_reg <= 1'b1;
                        buf_reg <= buf_next;
                        pos_reg <= pos_next;
                        if ((in_present && pos_reg == 6'd63) ||
                            (in_last && pos_next == 6'd0))
                            state_reg <= ST_PUSH;
                        else if (in_last)
                            state_reg <= ST_PAD;
                    end
                end
                ST_PAD: begin
                    if (pos_reg == 6'd56) begin
                        state_reg   <= ST_LEN;
                        len_idx_reg <= '0;
                    end else begin
                        buf_reg  <= put(buf_reg, pos_reg, pad_byte);
                        pos_reg  <= pos_reg + 6'd1;
                        mark_reg <= 1'b0;
                        if (pos_reg == 6'd63)
                            state_reg <= ST_PUSH;
                    end
                end
                ST_LEN: begin
                    buf_reg     <= put(buf_reg, pos_reg, pad_byte);
                    pos_reg     <= pos_reg + 6'd1;
                    len_idx_reg <= len_idx_reg + 3'd1;
                    if (len_idx_reg == 3'd7) begin
                        fin_reg   <= 1'b1;
                        state_reg <= ST_PUSH;
                    end
                end
                ST_PUSH: begin
                    if (!cmd_valid_reg) begin
                        cmd_reg.block      <= buf_reg;
                        cmd_reg.last_block <= fin_reg;
                        cmd_valid_reg      <= 1'b1;
                        if (fin_reg) begin
                            fin_reg       <= 1'b0;
                            pad_after_reg <= 1'b0;
                            len_reg       <= '0;
                            state_reg     <= ST_BYTES;
                        end else if (pad_after_reg) begin
                            state_reg <= ST_PAD;
                        end else begin
                            state_reg <= ST_BYTES;
                        end
                    end
                end
                default: state_reg <= ST_BYTES;
            endcase
        end
    end

endmodule

@@ hdl/sha256_back.sv @@
// Back end: 64-round compression, chain update and digest word output.
`timescale 1ns / 1ps
module sha256_back
    import sha256_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  blk_cmd_t    cmd,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    output logic [31:0] out_word,
    output logic [2:0]  out_num,
    output logic        out_final,
    output logic        out_valid,
    input  logic        out_ready
);

    typedef enum logic [1:0] {ST_IDLE, ST_ROUND, ST_ADD, ST_EMIT} bstate_t;

    bstate_t     state_reg;
    word_t       h_reg [8];
    word_t       v_reg [8];
    word_t       w_reg [16];
    logic [5:0]  r_reg;
    logic        last_reg;
    logic [2:0]  oidx_reg;
    logic        ovalid_reg;
    word_t       oword_reg;

    word_t wr, s0, s1, ch, mj, t1, t2, ls0, ls1, x15, x2;

    assign cmd_ready = (state_reg == ST_IDLE);
    assign out_word  = oword_reg;
    assign out_num   = oidx_reg;
    assign out_final = (oidx_reg == 3'd7);
    assign out_valid = ovalid_reg;

    always_comb begin
        // w_reg is a sliding window: w_reg[0] is w[r]
        x15 = w_reg[1];
        x2  = w_reg[14];
        ls0 = rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3);
        ls1 = rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10);
        wr  = w_reg[0];
        s1  = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
        ch  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1  = v_reg[7] + s1 + ch + round_k(r_reg) + wr;
        s0  = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
        mj  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2  = s0 + mj;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
            oidx_reg   <= '0;
            r_reg      <= '0;
            for (int i = 0; i < 8; i++) h_reg[i] <= H_INIT[i];
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (cmd_valid) begin
                        for (int i = 0; i < 16; i++)
                            w_reg[i] <= cmd.block[32*(15-i) +: 32];
                        for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i];
                        last_reg  <= cmd.last_block;
                        r_reg     <= '0;
                        state_reg <= ST_ROUND;
                    end
                end
                ST_ROUND: begin
                    for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i+1];
                    w_reg[15] <= w_reg[0] + ls0 + w_reg[9] + ls1;
                    v_reg[7] <= v_reg[6];
                    v_reg[6] <= v_reg[5];
                    v_reg[5] <= v_reg[4];
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[3] <= v_reg[2];
                    v_reg[2] <= v_reg[1];
                    v_reg[1] <= v_reg[0];
                    v_reg[0] <= t1 + t2;
                    r_reg    <= r_reg + 6'd1;
                    if (r_reg == 6'd63)
                        state_reg <= ST_ADD;
                end
                ST_ADD: begin
                    for (int i = 0; i < 8; i++) h_reg[i] <= h_reg[i] + v_reg[i];
                    if (last_reg) begin
                        oword_reg  <= h_reg[0] + v_reg[0];
                        oidx_reg   <= '0;
                        ovalid_reg <= 1'b1;
                        state_reg  <= ST_EMIT;
                    end else begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_EMIT: begin
                    if (out_ready) begin
                        if (oidx_reg == 3'd7) begin
                            ovalid_reg <= 1'b0;
                            for (int i = 0; i < 8; i++) h_reg[i] <= H_INIT[i];
                            state_reg  <= ST_IDLE;
                        end else begin
                            oidx_reg  <= oidx_reg + 3'd1;
                            oword_reg <= h_reg[oidx_reg + 3'd1];
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

@@ hdl/sha256_message_hasher_unit.sv @@
// Top level: streaming SHA-256 hasher, byte front end and compression back end.
`timescale 1ns / 1ps
// Usage
//   Slave channel: one message byte per transfer. s_axis_tdata[7:0] is the
//   byte, s_axis_tuser marks it present, s_axis_tlast ends the message.
//   A transfer with tlast and tuser low ends the message without a byte.
//   Master channel: eight transfers per message, h0 first. m_axis_tdata
//   carries the word, m_axis_tuser its number, m_axis_tlast the eighth.
// Timing
//   Bytes are taken at one per cycle while a block gathers and the
//   holding register is empty; a full block is handed to the compression
//   unit through this one-block holding register, so the next block
//   gathers during compression. The compression unit does one round a
//   cycle. After tlast the padding and length bytes are written, a full
//   block waiting while the compression unit is busy; one or two
//   compressions then run before the first digest word.
// Reset and stall
//   aresetn low (synchronous) clears the control state and restores the
//   initial hash. A stalled master holds the current word; the block then
//   stops taking input once its holding register is full.
module sha256_message_hasher_unit
    import sha256_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
    input  logic        s_axis_tuser,  // [0] byte_present
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,  // [2:0] word_number
    output logic        m_axis_tlast
);

    blk_cmd_t cmd;
    logic     cmd_valid, cmd_ready;

    sha256_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_byte(s_axis_tdata), .in_present(s_axis_tuser), .in_last(s_axis_tlast),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .cmd(cmd), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready)
    );

    sha256_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .cmd(cmd), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
        .out_word(m_axis_tdata), .out_num(m_axis_tuser), .out_final(m_axis_tlast),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready)
    );

endmodule

@@ hdl/sha256_checker.sv @@
// Output port checker for the SHA-256 hasher, bound to the top level.
`timescale 1ns / 1ps
module sha256_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("digest word changed while stalled");

    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 3'd7)))
        else $error("tlast not on word seven");

    a_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            m_axis_tvalid && m_axis_tuser == $past(m_axis_tuser) + 3'd1)
        else $error("digest words out of order");

    a_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
        else $error("output after last word");

endmodule

bind sha256_message_hasher_unit sha256_checker u_checker (
    .aclk(aclk), .aresetn(aresetn),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
);
